// File: hdl/euhp_pkg.sv
// Package for the Ethernet/IPv4/UDP header parser.
// Holds payload structs, result kind codes, header offsets and queue sizing.
// No dependencies.
`default_nettype none

package euhp_pkg;

    // result kinds
    localparam logic [2:0] K_HEADER   = 3'd0;
    localparam logic [2:0] K_PAYLOAD  = 3'd1;
    localparam logic [2:0] K_NOT_IPV4 = 3'd2;
    localparam logic [2:0] K_NOT_UDP  = 3'd3;
    localparam logic [2:0] K_TRUNC    = 3'd4;
    localparam logic [2:0] K_BADLEN   = 3'd5;

    // header byte offsets
    localparam logic [5:0] IDX_SRC_MAC = 6'd6;
    localparam logic [5:0] IDX_TYPE_HI = 6'd12;
    localparam logic [5:0] IDX_TYPE_LO = 6'd13;
    localparam logic [5:0] IDX_PROTO   = 6'd23;
    localparam logic [5:0] IDX_SRC_IP  = 6'd26;
    localparam logic [5:0] IDX_DST_IP  = 6'd30;
    localparam logic [5:0] IDX_PORTS   = 6'd34;
    localparam logic [5:0] IDX_LAST    = 6'd39;
    localparam logic [5:0] IDX_END     = 6'd40;

    localparam logic [7:0]  ETH_TYPE_HI = 8'h08;
    localparam logic [7:0]  ETH_TYPE_LO = 8'h00;
    localparam logic [7:0]  PROTO_UDP   = 8'h11;
    localparam logic [15:0] UDP_HDR_LEN = 16'd6;

    // decoupling queue
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_SKIP
    } t_phase;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_udp_port;
        logic [15:0] dst_udp_port;
        logic [15:0] payload_len;
        logic [7:0]  payload_byte;
        logic        packet_done;
    } t_out;

    // one queue entry: a result, optionally followed by a truncation result
    typedef struct packed {
        t_out res;
        logic add_trunc;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic t_out simple_result(logic [2:0] kind, logic done);
        t_out r;
        r             = '0;
        r.kind        = kind;
        r.packet_done = done;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/euhp_front.sv
// Front end of the header parser: takes one frame byte per cycle while the
// queue is not full, tracks the header offset and frame phase, and pushes
// results into the queue. Depends on euhp_pkg.
`default_nettype none

module euhp_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire euhp_pkg::t_in     i_data,
    input  wire euhp_pkg::t_q_stat i_q_stat,
    output logic                   o_push,
    output euhp_pkg::t_q_entry     o_entry
);
    import euhp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [5:0]  r_idx, n_idx;
    logic [15:0] r_rem, n_rem;
    logic [47:0] r_dst_mac, n_dst_mac;
    logic [47:0] r_src_mac, n_src_mac;
    logic [31:0] r_src_ip, n_src_ip;
    logic [31:0] r_dst_ip, n_dst_ip;
    logic [47:0] r_pl, n_pl;

    logic        acc;
    logic [7:0]  b;
    logic        last;
    logic [2:0]  fail_kind;
    logic [47:0] pl_shift;
    logic [15:0] len;
    logic [15:0] pay_len;
    logic [15:0] rem_dec;
    logic        hdr_done;

    assign o_ready  = ~i_q_stat.full;
    assign acc      = i_valid & ~i_q_stat.full;
    assign b        = i_data.frame_byte;
    assign last     = i_data.frame_end;
    assign pl_shift = {r_pl[39:0], b};
    assign len      = pl_shift[15:0];
    assign pay_len  = len - UDP_HDR_LEN;
    assign rem_dec  = r_rem - 16'd1;
    assign hdr_done = (r_idx >= IDX_LAST);

    always_comb begin
        fail_kind = K_HEADER;
        if (r_idx == IDX_TYPE_HI && b != ETH_TYPE_HI) begin
            fail_kind = K_NOT_IPV4;
        end else if (r_idx == IDX_TYPE_LO && b != ETH_TYPE_LO) begin
            fail_kind = K_NOT_IPV4;
        end else if (r_idx == IDX_PROTO && b != PROTO_UDP) begin
            fail_kind = K_NOT_UDP;
        end
    end

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_rem     = r_rem;
        n_dst_mac = r_dst_mac;
        n_src_mac = r_src_mac;
        n_src_ip  = r_src_ip;
        n_dst_ip  = r_dst_ip;
        n_pl      = r_pl;
        if (acc) begin
            unique case (r_phase)
                PH_PAYLOAD: begin
                    n_rem = rem_dec;
                    if (rem_dec == 16'd0) begin
                        n_phase = last ? PH_HEADER : PH_SKIP;
                        n_idx   = '0;
                    end else if (last) begin
                        n_phase = PH_HEADER;
                        n_idx   = '0;
                    end
                end
                PH_SKIP: begin
                    if (last) begin
                        n_phase = PH_HEADER;
                        n_idx   = '0;
                    end
                end
                PH_HEADER: begin
                    if (r_idx < IDX_SRC_MAC) begin
                        n_dst_mac = {r_dst_mac[39:0], b};
                    end else if (r_idx < IDX_TYPE_HI) begin
                        n_src_mac = {r_src_mac[39:0], b};
                    end else if (r_idx >= IDX_SRC_IP && r_idx < IDX_DST_IP) begin
                        n_src_ip = {r_src_ip[23:0], b};
                    end else if (r_idx >= IDX_DST_IP && r_idx < IDX_PORTS) begin
                        n_dst_ip = {r_dst_ip[23:0], b};
                    end else if (r_idx >= IDX_PORTS && r_idx < IDX_END) begin
                        n_pl = pl_shift;
                    end

                    if (fail_kind != K_HEADER) begin
                        n_phase = last ? PH_HEADER : PH_SKIP;
                        n_idx   = '0;
                    end else if (hdr_done) begin
                        n_idx = '0;
                        if (len < UDP_HDR_LEN || pay_len == 16'd0) begin
                            n_phase = last ? PH_HEADER : PH_SKIP;
                        end else if (last) begin
                            n_phase = PH_HEADER;
                        end else begin
                            n_phase = PH_PAYLOAD;
                            n_rem   = pay_len;
                        end
                    end else if (last) begin
                        n_idx = '0;
                    end else begin
                        n_idx = r_idx + 6'd1;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                    n_idx   = '0;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        o_push  = 1'b0;
        o_entry = '0;
        if (acc) begin
            unique case (r_phase)
                PH_PAYLOAD: begin
                    o_push                 = 1'b1;
                    o_entry.res            = simple_result(K_PAYLOAD, rem_dec == 16'd0);
                    o_entry.res.payload_byte = b;
                    o_entry.add_trunc      = (rem_dec != 16'd0) && last;
                end
                PH_SKIP: begin
                    o_push = 1'b0;
                end
                PH_HEADER: begin
                    if (fail_kind != K_HEADER) begin
                        o_push      = 1'b1;
                        o_entry.res = simple_result(fail_kind, 1'b1);
                    end else if (hdr_done) begin
                        o_push = 1'b1;
                        if (len < UDP_HDR_LEN) begin
                            o_entry.res = simple_result(K_BADLEN, 1'b1);
                        end else begin
                            o_entry.res = simple_result(K_HEADER, pay_len == 16'd0);
                            o_entry.res.dst_mac      = r_dst_mac;
                            o_entry.res.src_mac      = r_src_mac;
                            o_entry.res.src_ip       = r_src_ip;
                            o_entry.res.dst_ip       = r_dst_ip;
                            o_entry.res.src_udp_port = pl_shift[47:32];
                            o_entry.res.dst_udp_port = pl_shift[31:16];
                            o_entry.res.payload_len  = pay_len;
                            o_entry.add_trunc        = (pay_len != 16'd0) && last;
                        end
                    end else if (last) begin
                        o_push      = 1'b1;
                        o_entry.res = simple_result(K_TRUNC, 1'b1);
                    end
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_idx   <= '0;
            r_rem   <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_rem   <= n_rem;
        end
    end

    // header fields are fully shifted in before use
    always_ff @(posedge i_clk) begin
        r_dst_mac <= n_dst_mac;
        r_src_mac <= n_src_mac;
        r_src_ip  <= n_src_ip;
        r_dst_ip  <= n_dst_ip;
        r_pl      <= n_pl;
    end

endmodule

`default_nettype wire

// File: hdl/euhp_queue.sv
// Short queue between the parser front end and the result back end.
// Depends on euhp_pkg.
`default_nettype none

module euhp_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire euhp_pkg::t_q_entry i_entry,
    input  wire logic               i_pop,
    output euhp_pkg::t_q_entry      o_head,
    output euhp_pkg::t_q_stat       o_stat
);
    import euhp_pkg::*;

    t_q_entry       r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QAW:0]   r_count, n_count;
    logic           do_push;
    logic           do_pop;

    assign o_stat.full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push & ~o_stat.full;
    assign do_pop       = i_pop & ~o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + QAW'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + QAW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + (QAW+1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (QAW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// File: hdl/euhp_back.sv
// Back end of the header parser: drains the queue into the output register,
// expanding an entry marked for truncation into two results.
// Depends on euhp_pkg.
`default_nettype none

module euhp_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire euhp_pkg::t_q_entry i_head,
    input  wire euhp_pkg::t_q_stat  i_q_stat,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output euhp_pkg::t_out          o_data
);
    import euhp_pkg::*;

    logic r_valid, n_valid;
    logic r_trunc_pend, n_trunc_pend;
    t_out r_out, n_out;
    logic load;

    assign load    = ~r_valid | i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_out;

    always_comb begin
        n_valid      = r_valid;
        n_trunc_pend = r_trunc_pend;
        n_out        = r_out;
        o_pop        = 1'b0;
        if (load) begin
            if (r_trunc_pend) begin
                n_valid      = 1'b1;
                n_out        = simple_result(K_TRUNC, 1'b1);
                n_trunc_pend = 1'b0;
            end else if (!i_q_stat.empty) begin
                n_valid      = 1'b1;
                n_out        = i_head.res;
                n_trunc_pend = i_head.add_trunc;
                o_pop        = 1'b1;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_trunc_pend <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_trunc_pend <= n_trunc_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

`default_nettype wire

// File: hdl/eth_ipv4_udp_header_parser_core.sv
// Ethernet/IPv4/UDP header parser, top level. Takes one frame byte per cycle
// while the queue is not full; a result goes through the queue, then the
// output register. A truncation after a payload or header result is an extra
// output result, absorbed by the 4-entry queue.
// Reset: synchronous, active low; returns to the header phase at offset 0.
`default_nettype none

module eth_ipv4_udp_header_parser_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire euhp_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output euhp_pkg::t_out      o_out_data
);
    import euhp_pkg::*;

    logic     w_push;
    logic     w_pop;
    t_q_entry w_entry;
    t_q_entry w_head;
    t_q_stat  w_q_stat;

    euhp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_data   (i_in_data),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_entry  (w_entry)
    );

    euhp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    euhp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_data   (o_out_data)
    );

    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.full |-> !w_push)
        else $error("push into full queue");

    a_no_pop_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from empty queue");

    a_trunc_ends_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind == K_TRUNC) |-> o_out_data.packet_done)
        else $error("truncation result without packet_done");

    a_header_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind == K_HEADER)
            |-> (o_out_data.packet_done == (o_out_data.payload_len == 16'd0)))
        else $error("header packet_done disagrees with payload_len");

endmodule

`default_nettype wire
